// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/rmlr_pkg.sv =====
`default_nettype none

package rmlr_pkg;

    localparam int COLOR_BITS = 16;
    localparam int FIFO_DEPTH = 4;

    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_ADVANCE = 1'b1
    } t_command;

    typedef enum logic {
        REG_SCREEN_MAX_X = 1'b0,
        REG_SCREEN_MAX_Y = 1'b1
    } t_reg_index;

endpackage

`default_nettype wire

// ===== rtl/run_merged_line_rasterizer.sv =====
`default_nettype none

// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: x_begin y_begin x_end y_end color
//                                                   tuser: command
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: left right top bottom color
//                                                   tlast: last_run
// cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// One word per cycle in while s_axis_tready is high; one Bresenham step is done in the cycle the word is taken.
// Runs are registered in a four-entry result queue before they leave on m_axis.
// s_axis_tready is high while the queue has at least two free entries, so an advance that emits
// two runs always fits; one run per cycle out, while m_axis_tready is high, sets the rate.
// i_rst_n is synchronous: it empties the queue, drops any line and restores the maxima.

module run_merged_line_rasterizer
    import rmlr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    localparam int DATA_BITS = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // x_begin, y_begin, x_end, y_end, pixel_color (low to high)
    input  wire logic [DATA_BITS-1:0]  s_axis_tdata,
    // command
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // run_left, run_right, run_top, run_bottom, run_color (low to high)
    output logic [DATA_BITS-1:0]       m_axis_tdata,
    output logic                       m_axis_tlast,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic                  i_cfg_index,
    input  wire logic [COORD_BITS-1:0] i_cfg_data
);

    localparam int CB       = COORD_BITS;
    localparam int ERR_BITS = COORD_BITS + 3;
    localparam int PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS = PTR_BITS + 1;
    localparam logic [CB-1:0] ONE         = CB'(1);
    localparam logic [CB-1:0] MAX_X_RESET = CB'(239);
    localparam logic [CB-1:0] MAX_Y_RESET = CB'(319);
    localparam logic [CNT_BITS-1:0] READY_LIMIT = CNT_BITS'(FIFO_DEPTH - 2);

    function automatic logic [DATA_BITS-1:0] pack_run(
        input logic [CB-1:0]         xa,
        input logic [CB-1:0]         xb,
        input logic [CB-1:0]         ya,
        input logic [CB-1:0]         yb,
        input logic [COLOR_BITS-1:0] color,
        input logic [CB-1:0]         max_x,
        input logic [CB-1:0]         max_y
    );
        logic [CB-1:0]        lo_x;
        logic [CB-1:0]        hi_x;
        logic [CB-1:0]        lo_y;
        logic [CB-1:0]        hi_y;
        logic [DATA_BITS-1:0] word;
        lo_x = (xa > xb) ? xb : xa;
        hi_x = (xa > xb) ? xa : xb;
        lo_y = (ya > yb) ? yb : ya;
        hi_y = (ya > yb) ? ya : yb;
        word = '0;
        word[0 +: CB]          = (lo_x > max_x) ? max_x : lo_x;
        word[CB +: CB]         = (hi_x > max_x) ? max_x : hi_x;
        word[2 * CB +: CB]     = (lo_y > max_y) ? max_y : lo_y;
        word[3 * CB +: CB]     = (hi_y > max_y) ? max_y : hi_y;
        word[4 * CB +: COLOR_BITS] = color;
        return word;
    endfunction

    logic [CB-1:0]              r_max_x;
    logic [CB-1:0]              r_max_y;
    logic [CB-1:0]              r_pos_x;
    logic [CB-1:0]              r_pos_y;
    logic [CB-1:0]              r_tgt_x;
    logic [CB-1:0]              r_tgt_y;
    logic [CB-1:0]              r_rs_x;
    logic [CB-1:0]              r_rs_y;
    logic signed [ERR_BITS-1:0] r_err;
    logic [CB-1:0]              r_dx;
    logic [CB-1:0]              r_dy;
    logic                       r_neg_x;
    logic                       r_neg_y;
    logic [COLOR_BITS-1:0]      r_color;
    logic                       r_active;

    logic [DATA_BITS-1:0]       r_fifo_data [FIFO_DEPTH];
    logic                       r_fifo_last [FIFO_DEPTH];
    logic [PTR_BITS-1:0]        r_wr_ptr;
    logic [PTR_BITS-1:0]        r_rd_ptr;
    logic [CNT_BITS-1:0]        r_count;

    logic [CB-1:0]              in_xb;
    logic [CB-1:0]              in_yb;
    logic [CB-1:0]              in_xe;
    logic [CB-1:0]              in_ye;
    logic [COLOR_BITS-1:0]      in_color;
    logic [CB-1:0]              st_dx;
    logic [CB-1:0]              st_dy;

    logic                       accept;
    logic                       is_start;
    logic                       advance;
    logic                       pop;
    logic                       open_run;
    logic [CB-1:0]              back_x;
    logic [CB-1:0]              back_y;
    logic [CB-1:0]              fwd_x;
    logic [CB-1:0]              fwd_y;
    logic [CB-1:0]              rs_x_cur;
    logic [CB-1:0]              rs_y_cur;
    logic signed [ERR_BITS:0]   e2;
    logic signed [ERR_BITS:0]   dx_s;
    logic signed [ERR_BITS:0]   dy_neg;
    logic                       cx;
    logic                       cy;
    logic                       fin_x;
    logic                       fin_y;
    logic                       finish;
    logic                       step_x;
    logic                       step_y;
    logic [CB-1:0]              n_pos_x;
    logic [CB-1:0]              n_pos_y;
    logic signed [ERR_BITS-1:0] n_err;
    logic [DATA_BITS-1:0]       run_open;
    logic [DATA_BITS-1:0]       run_fin;
    logic                       push0;
    logic                       push1;
    logic [DATA_BITS-1:0]       data0;
    logic                       last0;

    assign in_xb    = s_axis_tdata[0 +: CB];
    assign in_yb    = s_axis_tdata[CB +: CB];
    assign in_xe    = s_axis_tdata[2 * CB +: CB];
    assign in_ye    = s_axis_tdata[3 * CB +: CB];
    assign in_color = s_axis_tdata[4 * CB +: COLOR_BITS];
    assign st_dx    = (in_xe > in_xb) ? (in_xe - in_xb) : (in_xb - in_xe);
    assign st_dy    = (in_ye > in_yb) ? (in_ye - in_yb) : (in_yb - in_ye);

    assign s_axis_tready = (r_count <= READY_LIMIT);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_start      = (s_axis_tuser == CMD_START);
    assign advance       = accept && !is_start && r_active;

    assign open_run = (r_rs_x != r_pos_x) && (r_rs_y != r_pos_y);
    assign back_x   = r_neg_x ? (r_pos_x + ONE) : (r_pos_x - ONE);
    assign back_y   = r_neg_y ? (r_pos_y + ONE) : (r_pos_y - ONE);
    assign fwd_x    = r_neg_x ? (r_pos_x - ONE) : (r_pos_x + ONE);
    assign fwd_y    = r_neg_y ? (r_pos_y - ONE) : (r_pos_y + ONE);
    assign rs_x_cur = open_run ? r_pos_x : r_rs_x;
    assign rs_y_cur = open_run ? r_pos_y : r_rs_y;

    assign e2     = {r_err, 1'b0};
    assign dx_s   = $signed({{(ERR_BITS + 1 - CB){1'b0}}, r_dx});
    assign dy_neg = -$signed({{(ERR_BITS + 1 - CB){1'b0}}, r_dy});
    assign cx     = (e2 >= dy_neg);
    assign cy     = (e2 <= dx_s);
    assign fin_x  = cx && (r_pos_x == r_tgt_x);
    assign step_x = cx && !fin_x;
    assign fin_y  = !fin_x && cy && (r_pos_y == r_tgt_y);
    assign step_y = !fin_x && cy && !fin_y;
    assign finish = fin_x || fin_y;

    assign n_pos_x = step_x ? fwd_x : r_pos_x;
    assign n_pos_y = step_y ? fwd_y : r_pos_y;
    assign n_err   = r_err
                   + (step_x ? dy_neg[ERR_BITS-1:0] : '0)
                   + (step_y ? dx_s[ERR_BITS-1:0] : '0);

    assign run_open = pack_run(r_rs_x, back_x, r_rs_y, back_y, r_color, r_max_x, r_max_y);
    assign run_fin  = pack_run(rs_x_cur, n_pos_x, rs_y_cur, r_pos_y, r_color,
                               r_max_x, r_max_y);

    assign push0 = advance && (open_run || finish);
    assign push1 = advance && open_run && finish;
    assign data0 = open_run ? run_open : run_fin;
    assign last0 = !open_run;

    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = r_fifo_data[r_rd_ptr];
    assign m_axis_tlast  = r_fifo_last[r_rd_ptr];
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_max_x  <= MAX_X_RESET;
            r_max_y  <= MAX_Y_RESET;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_SCREEN_MAX_X) begin
                    r_max_x <= i_cfg_data;
                end else begin
                    r_max_y <= i_cfg_data;
                end
            end
            if (accept && is_start) begin
                r_active <= 1'b1;
            end else if (advance && finish) begin
                r_active <= 1'b0;
            end
            r_wr_ptr <= r_wr_ptr + PTR_BITS'(push0) + PTR_BITS'(push1);
            r_rd_ptr <= r_rd_ptr + PTR_BITS'(pop);
            r_count  <= r_count + CNT_BITS'(push0) + CNT_BITS'(push1) - CNT_BITS'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_start) begin
            r_pos_x <= in_xb;
            r_pos_y <= in_yb;
            r_tgt_x <= in_xe;
            r_tgt_y <= in_ye;
            r_rs_x  <= in_xb;
            r_rs_y  <= in_yb;
            r_dx    <= st_dx;
            r_dy    <= st_dy;
            r_neg_x <= !(in_xb < in_xe);
            r_neg_y <= !(in_yb < in_ye);
            r_err   <= $signed({{(ERR_BITS - CB){1'b0}}, st_dx})
                     - $signed({{(ERR_BITS - CB){1'b0}}, st_dy});
            r_color <= in_color;
        end else if (advance) begin
            r_rs_x  <= rs_x_cur;
            r_rs_y  <= rs_y_cur;
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push0) begin
            r_fifo_data[r_wr_ptr] <= data0;
            r_fifo_last[r_wr_ptr] <= last0;
        end
        if (push1) begin
            r_fifo_data[r_wr_ptr + PTR_BITS'(1)] <= run_fin;
            r_fifo_last[r_wr_ptr + PTR_BITS'(1)] <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rmlr_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module rmlr_checker
    import rmlr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    localparam int DATA_BITS = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  s_axis_tuser,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [DATA_BITS-1:0]  m_axis_tdata,
    input wire logic                  m_axis_tlast,
    input wire logic                  i_cfg_valid,
    input wire logic                  o_cfg_ready
);

    localparam int CB = COORD_BITS;

    logic                 in_word;
    logic                 start_word;
    logic                 out_stall;
    logic [DATA_BITS:0]   out_word;
    logic                 run_ordered;

    assign in_word     = s_axis_tvalid && s_axis_tready;
    assign start_word  = in_word && (s_axis_tuser == CMD_START);
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign out_word    = {m_axis_tlast, m_axis_tdata};
    assign run_ordered = (m_axis_tdata[0 +: CB] <= m_axis_tdata[CB +: CB])
                      && (m_axis_tdata[2 * CB +: CB] <= m_axis_tdata[3 * CB +: CB]);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(out_word))
    `ASSERT_NEXT(a_no_spurious_run, i_clk, i_rst_n, !m_axis_tvalid && !in_word, !m_axis_tvalid)
    `ASSERT_NEXT(a_start_silent, i_clk, i_rst_n, !m_axis_tvalid && start_word, !m_axis_tvalid)
    `ASSERT_IMPLIES(a_run_ordered, i_clk, i_rst_n, m_axis_tvalid, run_ordered)
    `ASSERT_IMPLIES(a_cfg_always_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready)

endmodule

bind run_merged_line_rasterizer rmlr_checker #(.COORD_BITS(COORD_BITS)) u_rmlr_checker (.*);

`default_nettype wire
